// ===== src/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Shared widths, token and error codes, result types and the character
// class and keyword helpers used by the scanner and the result queue.
// ----------------------------------------------------------------------------
package stt_pkg;

	// Default widths of the position and line counters.
	localparam int OFFSET_BITS_DEF = 24;
	localparam int LINE_BITS_DEF   = 24;

	// Fixed widths of the result fields.
	localparam int FIELD_W = 24;
	localparam int KIND_W  = 5;
	localparam int ERR_W   = 2;
	localparam int BYTE_W  = 8;

	// Token kinds.
	localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd0;
	localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd1;
	localparam logic [KIND_W-1:0] KIND_STAR    = 5'd2;
	localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd3;
	localparam logic [KIND_W-1:0] KIND_EQUAL   = 5'd4;
	localparam logic [KIND_W-1:0] KIND_COLON   = 5'd5;
	localparam logic [KIND_W-1:0] KIND_DCOLON  = 5'd6;
	localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd7;
	localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd8;
	localparam logic [KIND_W-1:0] KIND_DOT     = 5'd9;
	localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd10;
	localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd11;
	localparam logic [KIND_W-1:0] KIND_LBRACE  = 5'd12;
	localparam logic [KIND_W-1:0] KIND_RBRACE  = 5'd13;
	localparam logic [KIND_W-1:0] KIND_LBRACK  = 5'd14;
	localparam logic [KIND_W-1:0] KIND_RBRACK  = 5'd15;
	localparam logic [KIND_W-1:0] KIND_STRING  = 5'd16;
	localparam logic [KIND_W-1:0] KIND_CHAR    = 5'd17;
	localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd18;
	localparam logic [KIND_W-1:0] KIND_INT     = 5'd19;
	localparam logic [KIND_W-1:0] KIND_KW0     = 5'd20;
	localparam logic [KIND_W-1:0] KIND_END     = 5'd23;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 5'd24;

	// Error kinds.
	localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
	localparam logic [ERR_W-1:0] ERR_OPEN_STR   = 2'd1;
	localparam logic [ERR_W-1:0] ERR_OPEN_CHAR  = 2'd2;
	localparam logic [ERR_W-1:0] ERR_UNEXPECTED = 2'd3;

	// Characters with a special role.
	localparam logic [BYTE_W-1:0] CH_EOT    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5F;

	// Keywords: return, struct, let. Each row is padded to eight slots so
	// that any three-bit character index stays in range.
	localparam int NUM_KW = 3;
	localparam int KW_MAX = 8;
	localparam logic [BYTE_W-1:0] KW_CHARS [NUM_KW][KW_MAX] = '{
		'{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E, 8'h00, 8'h00},
		'{8'h73, 8'h74, 8'h72, 8'h75, 8'h63, 8'h74, 8'h00, 8'h00},
		'{8'h6C, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd6, 3'd6, 3'd3};

	// One result item.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ERR_W-1:0]   err;
		logic [FIELD_W-1:0] start;
		logic [FIELD_W-1:0] len;
		logic [FIELD_W-1:0] line;
		logic [BYTE_W-1:0]  bad;
		logic               last;
	} result_t;

	// Up to two results that one byte produces, in order.
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} res_pair_t;

	function automatic logic dec_digit(input logic [BYTE_W-1:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic word_start(input logic [BYTE_W-1:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
			(c == CH_UNDER);
	endfunction

	function automatic logic is_space(input logic [BYTE_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	// Single-byte punctuators: valid flag and kind.
	function automatic logic [KIND_W:0] punct_kind(input logic [BYTE_W-1:0] c);
		logic [KIND_W:0] r;
		r = '0;
		case (c)
			8'h2B: r = {1'b1, KIND_PLUS};
			8'h2D: r = {1'b1, KIND_MINUS};
			8'h2A: r = {1'b1, KIND_STAR};
			8'h2F: r = {1'b1, KIND_SLASH};
			8'h3D: r = {1'b1, KIND_EQUAL};
			8'h3B: r = {1'b1, KIND_SEMI};
			8'h2C: r = {1'b1, KIND_COMMA};
			8'h2E: r = {1'b1, KIND_DOT};
			8'h28: r = {1'b1, KIND_LPAREN};
			8'h29: r = {1'b1, KIND_RPAREN};
			8'h7B: r = {1'b1, KIND_LBRACE};
			8'h7D: r = {1'b1, KIND_RBRACE};
			8'h5B: r = {1'b1, KIND_LBRACK};
			8'h5D: r = {1'b1, KIND_RBRACK};
			default: r = '0;
		endcase
		return r;
	endfunction

	// Drop every keyword whose character at this index does not match.
	function automatic logic [NUM_KW-1:0] kw_track(input logic [NUM_KW-1:0] live,
			input logic [BYTE_W-1:0] c, input logic idx_small, input logic [2:0] idx);
		logic [NUM_KW-1:0] r;
		r = live;
		for (int k = 0; k < NUM_KW; k++) begin
			if (!idx_small || (idx >= KW_LEN[k]) || (KW_CHARS[k][idx] != c)) begin
				r[k] = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

// ===== src/stt_scan.sv =====
// ----------------------------------------------------------------------------
// Tokenizer scan stage
// Holds the scan state and turns one text byte into up to two results and
// the next state in combinational logic.
// ----------------------------------------------------------------------------
module stt_scan #(
	parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
	parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [stt_pkg::BYTE_W-1:0]    text_byte,
	output stt_pkg::res_pair_t            pair
);

	localparam int FW = stt_pkg::FIELD_W;
	localparam int NK = stt_pkg::NUM_KW;

	// Scan modes.
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_COLON   = 3'd1;
	localparam logic [2:0] MODE_IDENT   = 3'd2;
	localparam logic [2:0] MODE_INT     = 3'd3;
	localparam logic [2:0] MODE_STRING  = 3'd4;
	localparam logic [2:0] MODE_CHAR    = 3'd5;
	localparam logic [2:0] MODE_DISCARD = 3'd6;

	logic [2:0]             mode_q, mode_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n;
	logic [LINE_BITS-1:0]   line_q, line_n;
	logic [OFFSET_BITS-1:0] pstart_q, pstart_n;
	logic [NK-1:0]          kw_q, kw_n;
	logic                   bs_q, bs_n;
	logic [LINE_BITS-1:0]   qline_q, qline_n;

	logic [OFFSET_BITS-1:0] pos_inc, len_now, len_inc;
	logic [LINE_BITS-1:0]   line_adv;
	logic                   idx_small;
	logic [stt_pkg::KIND_W-1:0] ident_kind;
	logic [stt_pkg::KIND_W:0]   punct;
	logic                   is_str;
	logic [stt_pkg::BYTE_W-1:0] quote_ch;
	logic                   flush_v, run_idle, idle_v;
	stt_pkg::result_t       flush_r, idle_r;

	function automatic stt_pkg::result_t make_res(input logic [stt_pkg::KIND_W-1:0] kind,
			input logic [stt_pkg::ERR_W-1:0] err, input logic [OFFSET_BITS-1:0] start,
			input logic [OFFSET_BITS-1:0] len, input logic [LINE_BITS-1:0] line,
			input logic [stt_pkg::BYTE_W-1:0] bad);
		stt_pkg::result_t r;
		r.kind  = kind;
		r.err   = err;
		r.start = FW'(start);
		r.len   = FW'(len);
		r.line  = FW'(line);
		r.bad   = bad;
		r.last  = 1'b0;
		return r;
	endfunction

	// Counters as they stand after this byte is consumed.
	assign pos_inc   = pos_q + OFFSET_BITS'(1);
	assign line_adv  = line_q + LINE_BITS'(text_byte == stt_pkg::CH_LF);
	assign len_now   = pos_q - pstart_q;
	assign len_inc   = pos_inc - pstart_q;
	assign idx_small = len_now < OFFSET_BITS'(8);
	assign punct     = stt_pkg::punct_kind(text_byte);
	assign is_str    = mode_q == MODE_STRING;
	assign quote_ch  = is_str ? stt_pkg::CH_DQUOTE : stt_pkg::CH_SQUOTE;

	// Keyword decision on an exact length match; the first live keyword wins.
	always_comb begin
		ident_kind = stt_pkg::KIND_IDENT;
		for (int k = NK - 1; k >= 0; k--) begin
			if (kw_q[k] && (len_now == OFFSET_BITS'(stt_pkg::KW_LEN[k]))) begin
				ident_kind = stt_pkg::KIND_KW0 + stt_pkg::KIND_W'(k);
			end
		end
	end

	// Per-byte state update and result generation.
	always_comb begin
		mode_n   = mode_q;
		pos_n    = pos_q;
		line_n   = line_q;
		pstart_n = pstart_q;
		kw_n     = kw_q;
		bs_n     = bs_q;
		qline_n  = qline_q;
		flush_v  = 1'b0;
		flush_r  = '0;
		run_idle = 1'b0;
		idle_v   = 1'b0;
		idle_r   = '0;

		// A pending token either grows or is closed by this byte.
		unique case (mode_q)
			MODE_COLON: begin
				flush_v = 1'b1;
				if (text_byte == stt_pkg::CH_COLON) begin
					flush_r = make_res(stt_pkg::KIND_DCOLON, stt_pkg::ERR_NONE, pstart_q,
						len_inc, line_q, '0);
					pos_n  = pos_inc;
					mode_n = MODE_IDLE;
				end else begin
					flush_r = make_res(stt_pkg::KIND_COLON, stt_pkg::ERR_NONE, pstart_q,
						len_now, line_q, '0);
					run_idle = 1'b1;
				end
			end
			MODE_IDENT: begin
				if (stt_pkg::word_start(text_byte) || stt_pkg::dec_digit(text_byte)) begin
					kw_n  = stt_pkg::kw_track(kw_q, text_byte, idx_small, len_now[2:0]);
					pos_n = pos_inc;
				end else begin
					flush_v  = 1'b1;
					flush_r  = make_res(ident_kind, stt_pkg::ERR_NONE, pstart_q, len_now,
						line_q, '0);
					run_idle = 1'b1;
				end
			end
			MODE_INT: begin
				if (stt_pkg::dec_digit(text_byte)) begin
					pos_n = pos_inc;
				end else begin
					flush_v  = 1'b1;
					flush_r  = make_res(stt_pkg::KIND_INT, stt_pkg::ERR_NONE, pstart_q,
						len_now, line_q, '0);
					run_idle = 1'b1;
				end
			end
			MODE_STRING, MODE_CHAR: begin
				if (text_byte == stt_pkg::CH_EOT) begin
					flush_v  = 1'b1;
					flush_r  = make_res(stt_pkg::KIND_ERROR,
						is_str ? stt_pkg::ERR_OPEN_STR : stt_pkg::ERR_OPEN_CHAR,
						pstart_q, len_now, qline_q, '0);
					run_idle = 1'b1;
				end else begin
					bs_n   = text_byte == stt_pkg::CH_BSLASH;
					pos_n  = pos_inc;
					line_n = line_adv;
					if ((text_byte == quote_ch) && !bs_q) begin
						flush_v = 1'b1;
						flush_r = make_res(is_str ? stt_pkg::KIND_STRING : stt_pkg::KIND_CHAR,
							stt_pkg::ERR_NONE, pstart_q, len_inc, line_adv, '0);
						mode_n  = MODE_IDLE;
						bs_n    = 1'b0;
					end
				end
			end
			MODE_DISCARD: begin
				if (text_byte == stt_pkg::CH_EOT) begin
					run_idle = 1'b1;
				end else begin
					pos_n  = pos_inc;
					line_n = line_adv;
				end
			end
			default: begin
				run_idle = 1'b1;
			end
		endcase

		// Handling of a byte seen between tokens.
		if (run_idle) begin
			mode_n = MODE_IDLE;
			if (text_byte == stt_pkg::CH_EOT) begin
				idle_v   = 1'b1;
				idle_r   = make_res(stt_pkg::KIND_END, stt_pkg::ERR_NONE, pos_q, '0,
					line_q, '0);
				pos_n    = '0;
				line_n   = '0;
				pstart_n = '0;
				kw_n     = '1;
				bs_n     = 1'b0;
				qline_n  = '0;
			end else begin
				pos_n  = pos_inc;
				line_n = line_adv;
				if (stt_pkg::is_space(text_byte)) begin
					// Whitespace only moves the counters.
				end else if (punct[stt_pkg::KIND_W]) begin
					idle_v = 1'b1;
					idle_r = make_res(punct[stt_pkg::KIND_W-1:0], stt_pkg::ERR_NONE, pos_q,
						OFFSET_BITS'(1), line_q, '0);
				end else if (text_byte == stt_pkg::CH_COLON) begin
					mode_n   = MODE_COLON;
					pstart_n = pos_q;
				end else if ((text_byte == stt_pkg::CH_DQUOTE) ||
						(text_byte == stt_pkg::CH_SQUOTE)) begin
					mode_n   = (text_byte == stt_pkg::CH_DQUOTE) ? MODE_STRING : MODE_CHAR;
					pstart_n = pos_q;
					qline_n  = line_q;
					bs_n     = 1'b0;
				end else if (stt_pkg::word_start(text_byte)) begin
					mode_n   = MODE_IDENT;
					pstart_n = pos_q;
					kw_n     = stt_pkg::kw_track('1, text_byte, 1'b1, 3'd0);
				end else if (stt_pkg::dec_digit(text_byte)) begin
					mode_n   = MODE_INT;
					pstart_n = pos_q;
				end else begin
					idle_v = 1'b1;
					idle_r = make_res(stt_pkg::KIND_ERROR, stt_pkg::ERR_UNEXPECTED, pos_q,
						OFFSET_BITS'(1), line_q, text_byte);
					mode_n = MODE_DISCARD;
				end
			end
		end

		// Order the results and mark the final one of this byte.
		if (flush_v) begin
			pair.r0    = flush_r;
			pair.r1    = idle_r;
			pair.count = idle_v ? 2'd2 : 2'd1;
		end else begin
			pair.r0    = idle_r;
			pair.r1    = '0;
			pair.count = idle_v ? 2'd1 : 2'd0;
		end
		if (pair.count == 2'd2) begin
			pair.r1.last = 1'b1;
		end else begin
			pair.r0.last = 1'b1;
		end
	end

	// Scan state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			line_q   <= '0;
			pstart_q <= '0;
			kw_q     <= '1;
			bs_q     <= 1'b0;
			qline_q  <= '0;
		end else if (step) begin
			mode_q   <= mode_n;
			pos_q    <= pos_n;
			line_q   <= line_n;
			pstart_q <= pstart_n;
			kw_q     <= kw_n;
			bs_q     <= bs_n;
			qline_q  <= qline_n;
		end
	end

endmodule

// ===== src/stt_outq.sv =====
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Two-entry output buffer. It loads both results of one byte at once and
// presents them one transfer at a time.
// ----------------------------------------------------------------------------
module stt_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  stt_pkg::res_pair_t pair,
	input  logic               out_ready,
	output logic               out_valid,
	output stt_pkg::result_t   head,
	output logic               room
);

	logic [1:0]       count_q;
	stt_pkg::result_t q0_q, q1_q;
	logic             pop;

	assign out_valid = count_q != 2'd0;
	assign pop       = out_valid && out_ready;
	assign head      = q0_q;

	// The queue takes a new byte's results only when it is empty or its last entry leaves this cycle.
	assign room = (count_q == 2'd0) || ((count_q == 2'd1) && out_ready);

	// Occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (load) begin
			count_q <= pair.count;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	// Entries.
	always_ff @(posedge clk) begin
		if (load) begin
			q0_q <= pair.r0;
			q1_q <= pair.r1;
		end else if (pop) begin
			q0_q <= q1_q;
		end
	end

endmodule

// ===== src/source_text_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Source text tokenizer
// Flow: a byte is held in the input register and scanned once the result
// queue has room; its results are then registered in the result queue.
// Throughput: one byte per cycle while results are taken; a byte that gives
// two results holds the input while the two-entry result queue drains.
// Reset: arst_n clears the scan state and empties the input and result stages.
// Scans source text one byte per transfer and emits tokens with kind,
// start offset, length and line number.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
	parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
	parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [stt_pkg::BYTE_W-1:0]   text_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [stt_pkg::KIND_W-1:0]   token_kind,
	output logic [stt_pkg::ERR_W-1:0]    error_kind,
	output logic [stt_pkg::FIELD_W-1:0]  token_start,
	output logic [stt_pkg::FIELD_W-1:0]  token_length,
	output logic [stt_pkg::FIELD_W-1:0]  line_number,
	output logic [stt_pkg::BYTE_W-1:0]   bad_byte,
	output logic                         last_result
);

	logic                       valid_s1;
	logic [stt_pkg::BYTE_W-1:0] byte_s1;
	logic                       room;
	logic                       step;
	stt_pkg::res_pair_t         pair;
	stt_pkg::result_t           head;

	// The registered byte is scanned once the result queue can hold its output.
	assign step     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
		end
	end

	stt_scan #(
		.OFFSET_BITS(OFFSET_BITS),
		.LINE_BITS(LINE_BITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.text_byte(byte_s1),
		.pair(pair)
	);

	stt_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.load(step),
		.pair(pair),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.head(head),
		.room(room)
	);

	// Result fields.
	assign token_kind   = head.kind;
	assign error_kind   = head.err;
	assign token_start  = head.start;
	assign token_length = head.len;
	assign line_number  = head.line;
	assign bad_byte     = head.bad;
	assign last_result  = head.last;

endmodule

// ===== src/stt_checker.sv =====
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Watches the top level's ports for a steady input handshake and for
// consistency of the result fields.
// ----------------------------------------------------------------------------
module stt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [stt_pkg::BYTE_W-1:0]   text_byte,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [stt_pkg::KIND_W-1:0]   token_kind,
	input logic [stt_pkg::ERR_W-1:0]    error_kind,
	input logic [stt_pkg::FIELD_W-1:0]  token_start,
	input logic [stt_pkg::FIELD_W-1:0]  token_length,
	input logic [stt_pkg::FIELD_W-1:0]  line_number,
	input logic [stt_pkg::BYTE_W-1:0]   bad_byte,
	input logic                         last_result
);

	// An offered byte stays put until its transfer.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(text_byte))
		else $error("input byte changed while waiting");

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
		$stable(token_start) && $stable(token_length) && $stable(line_number))
		else $error("result changed while stalled");

	// Only an error result carries an error code.
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind != stt_pkg::KIND_ERROR) |-> error_kind == stt_pkg::ERR_NONE)
		else $error("error code on a non-error result");

	// The end result is empty and always closes its byte.
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == stt_pkg::KIND_END) |-> last_result &&
		(token_length == '0))
		else $error("malformed end result");

	// A bad byte is reported only for an unexpected byte.
	a_bad_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_kind != stt_pkg::ERR_UNEXPECTED) |-> bad_byte == '0)
		else $error("bad byte on a result without an unexpected byte");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.text_byte(text_byte),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.token_kind(token_kind),
	.error_kind(error_kind),
	.token_start(token_start),
	.token_length(token_length),
	.line_number(line_number),
	.bad_byte(bad_byte),
	.last_result(last_result)
);
